// File: hw/rtl/pipm_pkg.sv
package pipm_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  // field widths
  localparam int FUNC_W   = 3;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 3;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 3'd0,
    FN_PUSH   = 3'd1,
    FN_FWD    = 3'd2,
    FN_INV    = 3'd3,
    FN_LOAD   = 3'd4,
    FN_FINISH = 3'd5
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_NOTPART  = 3'd2,
    ST_DUP      = 3'd3,
    ST_MISSING  = 3'd4,
    ST_TOOLARGE = 3'd5
  } status_t;

  // clearing sequencer states
  typedef enum logic {
    CLR_IDLE,
    CLR_SWEEP
  } clr_state_t;

  // command transaction
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  index;
    logic [IDX_W-1:0]  entry_value;
    logic              entry_present;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic [IDX_W-1:0]    mapped_index;
    logic                is_participating;
    logic [CNT_W-1:0]    mapped_count;
    logic [STATUS_W-1:0] status;
  } result_t;

  // one map entry as held in memory
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // paired write into forward and inverse maps
  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] fwd_addr;
    entry_t            fwd_data;
    logic [TBL_AW-1:0] inv_addr;
    entry_t            inv_data;
  } wr_t;

  // clearing sweep control
  typedef struct packed {
    logic              active;
    logic [TBL_AW-1:0] addr;
  } clr_t;

endpackage

// File: hw/rtl/partial_index_permutation_map.sv
// Partial permutation index map: forward map from domain indices to compact
// permuted indices, its inverse, and a running entry count.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Every command gives exactly one result on result, marked by done for one
// cycle; the receiver cannot hold results off and needs none.
// A command passes through the input stage register and then the result
// register that drives done. Throughput: one command per cycle for push,
// lookups, load and finish while no clear or clearing sweep holds busy high.
// A clear returns its result at once and then sweeps both map memories, one
// entry a cycle, holding busy high until the sweep has passed the last entry.
// Configuration: cfg_ready is always high. The user must write the domain
// length via cfg_valid/cfg_data only while the block is idle; it is not checked.
// Reset (rst, synchronous) zeroes the counters and starts the same clearing
// sweep; no command is taken until it ends.
// Map reads are issued as a command is taken and the answer is formed in the
// next cycle, with the write of the previous command forwarded around the
// memories.
module partial_index_permutation_map
  import pipm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             done,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0]  domain_len;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  largest;
  logic              s1_valid;
  cmd_t              s1_item;
  logic [TBL_AW-1:0] s1_inv_addr;
  logic              lw_valid;
  wr_t               lw;
  logic              accept;
  logic              clear_req;
  logic [CNT_W-1:0]  count_now;
  logic [TBL_AW-1:0] inv_raddr;
  logic [ENTRY_W-1:0] fwd_rdata;
  logic [ENTRY_W-1:0] inv_rdata;
  entry_t            fwd_rd;
  entry_t            inv_rd;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  largest_next;
  wr_t               wr;
  result_t           res;
  clr_t              clr;
  logic              fwd_we;
  logic              inv_we;
  logic [TBL_AW-1:0] fwd_waddr;
  logic [TBL_AW-1:0] inv_waddr;
  logic [ENTRY_W-1:0] fwd_wdata;
  logic [ENTRY_W-1:0] inv_wdata;

  // handshake
  assign clear_req = s1_valid && (s1_item.func == FN_CLEAR);
  assign busy      = clr.active || clear_req;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      domain_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      domain_len <= cfg_data;
    end
  end

  // inverse read address depends on the operation; push uses the count after
  // the transaction now in flight
  always_comb begin
    count_now = s1_valid ? count_next : entry_count;
    case (cmd.func)
      FN_PUSH: inv_raddr = TBL_AW'(count_now);
      FN_LOAD: inv_raddr = TBL_AW'(cmd.entry_value);
      default: inv_raddr = TBL_AW'(cmd.index);
    endcase
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_item     <= cmd;
      s1_inv_addr <= inv_raddr;
    end
  end

  // memory write muxing: clearing sweep or paired store
  always_comb begin
    if (clr.active) begin
      fwd_we    = 1'b1;
      inv_we    = 1'b1;
      fwd_waddr = clr.addr;
      inv_waddr = clr.addr;
      fwd_wdata = '0;
      inv_wdata = '0;
    end else begin
      fwd_we    = s1_valid && wr.en;
      inv_we    = s1_valid && wr.en;
      fwd_waddr = wr.fwd_addr;
      inv_waddr = wr.inv_addr;
      fwd_wdata = wr.fwd_data;
      inv_wdata = wr.inv_data;
    end
  end

  pipm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .raddr (TBL_AW'(cmd.index)),
    .rdata (fwd_rdata)
  );

  pipm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_waddr),
    .wdata (inv_wdata),
    .raddr (inv_raddr),
    .rdata (inv_rdata)
  );

  // last write, forwarded to the transaction that read alongside it
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else begin
      lw_valid <= s1_valid && wr.en && !clr.active;
    end
    lw <= wr;
  end

  always_comb begin
    fwd_rd = fwd_rdata;
    inv_rd = inv_rdata;
    if (lw_valid && lw.fwd_addr == TBL_AW'(s1_item.index)) begin
      fwd_rd = lw.fwd_data;
    end
    if (lw_valid && lw.inv_addr == s1_inv_addr) begin
      inv_rd = lw.inv_data;
    end
  end

  pipm_exec u_exec (
    .item         (s1_item),
    .fwd          (fwd_rd),
    .inv          (inv_rd),
    .inv_addr     (s1_inv_addr),
    .domain_len   (domain_len),
    .count        (entry_count),
    .largest      (largest),
    .count_next   (count_next),
    .largest_next (largest_next),
    .wr           (wr),
    .res          (res)
  );

  pipm_clear u_clear (
    .clk       (clk),
    .rst       (rst),
    .clear_req (clear_req),
    .clr       (clr)
  );

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      largest     <= '0;
    end else if (s1_valid) begin
      entry_count <= count_next;
      largest     <= largest_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    if (s1_valid) begin
      result <= res;
    end
  end

`ifndef SYNTHESIS
  a_count_within_largest: assert property (@(posedge clk) disable iff (rst)
    entry_count <= largest)
    else $error("entry count exceeds largest value plus one");

  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    clear_req |=> (entry_count == '0 && largest == '0 && clr.active))
    else $error("clear did not zero counters and start the sweep");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.mapped_count == entry_count))
    else $error("reported count differs from held count");
`endif

endmodule

// File: hw/rtl/pipm_ram.sv
module pipm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read returning the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pipm_clear.sv
module pipm_clear
  import pipm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic clear_req,
  output clr_t clr
);

  clr_state_t        state;
  clr_state_t        state_next;
  logic [TBL_AW-1:0] addr;
  logic [TBL_AW-1:0] addr_next;

  // state and sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR_SWEEP;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  // sweep one entry a cycle over both maps
  always_comb begin
    state_next = state;
    addr_next  = addr;
    clr.active = 1'b0;
    clr.addr   = addr;
    case (state)
      CLR_IDLE: begin
        if (clear_req) begin
          state_next = CLR_SWEEP;
          addr_next  = '0;
        end
      end
      CLR_SWEEP: begin
        clr.active = 1'b1;
        if (addr == TBL_AW'(TABLE_DEPTH - 1)) begin
          state_next = CLR_IDLE;
          addr_next  = '0;
        end else begin
          addr_next = addr + TBL_AW'(1);
        end
      end
      default: begin
        state_next = CLR_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pipm_exec.sv
module pipm_exec
  import pipm_pkg::*;
(
  input  cmd_t             item,
  input  entry_t           fwd,
  input  entry_t           inv,
  input  logic [TBL_AW-1:0] inv_addr,
  input  logic [CNT_W-1:0] domain_len,
  input  logic [CNT_W-1:0] count,
  input  logic [CNT_W-1:0] largest,
  output logic [CNT_W-1:0] count_next,
  output logic [CNT_W-1:0] largest_next,
  output wr_t              wr,
  output result_t          res
);

  logic [CNT_W-1:0]    dom;
  logic [CNT_W-1:0]    idx_w;
  logic [CNT_W-1:0]    val_w;
  logic [CNT_W-1:0]    perm_inc;
  logic                idx_oor;
  logic                val_oor;
  logic                do_store;
  logic                do_clear;
  logic [IDX_W-1:0]    perm;
  logic [IDX_W-1:0]    mapped;
  logic                part;
  logic [STATUS_W-1:0] status;

  // effective domain and range checks
  always_comb begin
    dom     = (domain_len > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : domain_len;
    idx_w   = {1'b0, item.index};
    val_w   = {1'b0, item.entry_value};
    idx_oor = (idx_w >= dom);
    val_oor = (val_w >= dom);
  end

  // per-operation decision
  always_comb begin
    do_store = 1'b0;
    do_clear = 1'b0;
    perm     = '0;
    mapped   = '0;
    part     = 1'b0;
    status   = ST_OK;
    case (item.func)
      FN_CLEAR: begin
        do_clear = 1'b1;
      end
      FN_PUSH: begin
        if (idx_oor) begin
          status = ST_RANGE;
        end else if (fwd.valid) begin
          mapped = fwd.data;
          part   = 1'b1;
        end else if (count >= CNT_W'(TABLE_DEPTH) || inv.valid) begin
          status = ST_DUP;
        end else begin
          do_store = 1'b1;
          perm     = count[IDX_W-1:0];
          mapped   = count[IDX_W-1:0];
          part     = 1'b1;
        end
      end
      FN_FWD: begin
        if (idx_oor) begin
          status = ST_RANGE;
        end else if (fwd.valid) begin
          mapped = fwd.data;
          part   = 1'b1;
        end else begin
          status = ST_NOTPART;
        end
      end
      FN_INV: begin
        if (idx_w >= largest) begin
          status = ST_RANGE;
        end else if (inv.valid) begin
          mapped = inv.data;
          part   = 1'b1;
        end else begin
          status = ST_NOTPART;
        end
      end
      FN_LOAD: begin
        if (idx_oor) begin
          status = ST_RANGE;
        end else if (!item.entry_present) begin
          if (fwd.valid) begin
            mapped = fwd.data;
            part   = 1'b1;
          end
        end else if (val_oor) begin
          status = ST_TOOLARGE;
        end else if (fwd.valid || inv.valid) begin
          status = ST_DUP;
        end else begin
          do_store = 1'b1;
          perm     = item.entry_value;
          mapped   = item.entry_value;
          part     = 1'b1;
        end
      end
      FN_FINISH: begin
        if (count != largest) begin
          status = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
  end

  // counters after this transaction
  always_comb begin
    perm_inc = {1'b0, perm} + CNT_W'(1);
    if (do_clear) begin
      count_next   = '0;
      largest_next = '0;
    end else if (do_store) begin
      count_next   = count + CNT_W'(1);
      largest_next = (perm_inc > largest) ? perm_inc : largest;
    end else begin
      count_next   = count;
      largest_next = largest;
    end
  end

  // paired map write; inverse address was chosen at issue and equals perm on a store
  always_comb begin
    wr.en            = do_store;
    wr.fwd_addr      = TBL_AW'(item.index);
    wr.fwd_data      = '{valid: 1'b1, data: perm};
    wr.inv_addr      = do_store ? TBL_AW'(perm) : inv_addr;
    wr.inv_data      = '{valid: 1'b1, data: item.index};
    res.mapped_index     = mapped;
    res.is_participating = part;
    res.mapped_count     = count_next;
    res.status           = status;
  end

endmodule

// File: verif/tb_partial_index_permutation_map.sv
`timescale 1ns / 1ps

module tb_partial_index_permutation_map
  import pipm_pkg::*;
();

  // func codes the block does not use
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
  localparam int MAX_GAP = 14;
  localparam int MAX_REPORTS = 10;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  cmd_t             cmd;
  logic             done;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  partial_index_permutation_map dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // shadow copy of both maps and the counters
  logic [IDX_W-1:0] fwd_map [TABLE_DEPTH];
  bit               fwd_ok  [TABLE_DEPTH];
  logic [IDX_W-1:0] inv_map [TABLE_DEPTH];
  bit               inv_ok  [TABLE_DEPTH];
  logic [CNT_W-1:0] entry_total;
  logic [CNT_W-1:0] top_value;
  logic [CNT_W-1:0] domain_cfg;

  result_t awaited_results [$];
  int      mismatches;
  bit      back_to_back;

  function automatic void wipe_maps();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      fwd_ok[i] = 1'b0;
      inv_ok[i] = 1'b0;
    end
    entry_total = '0;
    top_value   = '0;
  endfunction

  function automatic void record_pair(logic [IDX_W-1:0] d, logic [IDX_W-1:0] p);
    fwd_map[d] = p;
    fwd_ok[d]  = 1'b1;
    inv_map[p] = d;
    inv_ok[p]  = 1'b1;
    entry_total = entry_total + CNT_W'(1);
    if (CNT_W'(p) + CNT_W'(1) > top_value) top_value = CNT_W'(p) + CNT_W'(1);
  endfunction

  // work out the result of one command and update the shadow maps
  function automatic result_t apply_map_cmd(cmd_t c);
    result_t r;
    int      span;
    r = '0;
    r.status = ST_OK;
    span = (domain_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(domain_cfg);
    case (c.func)
      FN_CLEAR: wipe_maps();
      FN_PUSH: begin
        if (c.index >= span) begin
          r.status = ST_RANGE;
        end else if (fwd_ok[c.index]) begin
          r.mapped_index = fwd_map[c.index];
          r.is_participating = 1'b1;
        end else if (entry_total >= TABLE_DEPTH || inv_ok[entry_total[TBL_AW-1:0]]) begin
          r.status = ST_DUP;
        end else begin
          r.mapped_index = entry_total[IDX_W-1:0];
          r.is_participating = 1'b1;
          record_pair(c.index, entry_total[IDX_W-1:0]);
        end
      end
      FN_FWD: begin
        if (c.index >= span) begin
          r.status = ST_RANGE;
        end else if (fwd_ok[c.index]) begin
          r.mapped_index = fwd_map[c.index];
          r.is_participating = 1'b1;
        end else begin
          r.status = ST_NOTPART;
        end
      end
      FN_INV: begin
        if (CNT_W'(c.index) >= top_value) begin
          r.status = ST_RANGE;
        end else if (inv_ok[c.index]) begin
          r.mapped_index = inv_map[c.index];
          r.is_participating = 1'b1;
        end else begin
          r.status = ST_NOTPART;
        end
      end
      FN_LOAD: begin
        if (c.index >= span) begin
          r.status = ST_RANGE;
        end else if (!c.entry_present) begin
          if (fwd_ok[c.index]) begin
            r.mapped_index = fwd_map[c.index];
            r.is_participating = 1'b1;
          end
        end else if (c.entry_value >= span) begin
          r.status = ST_TOOLARGE;
        end else if (fwd_ok[c.index] || inv_ok[c.entry_value]) begin
          r.status = ST_DUP;
        end else begin
          record_pair(c.index, c.entry_value);
          r.mapped_index = c.entry_value;
          r.is_participating = 1'b1;
        end
      end
      FN_FINISH: begin
        if (entry_total != top_value) r.status = ST_MISSING;
      end
      default: ;
    endcase
    r.mapped_count = entry_total;
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [FUNC_W-1:0] f, int idx, int val, bit pres);
    cmd_t c;
    c.func          = f;
    c.index         = IDX_W'(idx);
    c.entry_value   = IDX_W'(val);
    c.entry_present = pres;
    return c;
  endfunction

  function automatic void shuffle_ints(ref int a[TABLE_DEPTH], input int n);
    int j;
    int t;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = a[i];
      a[i] = a[j];
      a[j] = t;
    end
  endfunction

  // drive one command transaction and record its expected result
  task automatic send_cmd(input cmd_t c);
    int gap;
    if ($urandom_range(0, 49) == 0) back_to_back = !back_to_back;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_results.insert(awaited_results.size(), apply_map_cmd(c));
  endtask

  // write the domain length once the block has gone quiet
  task automatic set_domain(input int d);
    @(negedge clk);
    start <= 1'b0;
    while (busy || awaited_results.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(d);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    domain_cfg = CNT_W'(d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // extremes of the fields and each special case in turn
  task automatic test_directed();
    set_domain(0);
    send_cmd(make_cmd(FN_PUSH, 0, 0, 1'b0));
    send_cmd(make_cmd(FN_FWD, 1023, 0, 1'b0));
    send_cmd(make_cmd(FN_LOAD, 0, 0, 1'b1));
    send_cmd(make_cmd(FN_INV, 0, 0, 1'b0));
    send_cmd(make_cmd(FN_FINISH, 0, 0, 1'b0));
    send_cmd(make_cmd(FN_SPARE_A, 1023, 1023, 1'b1));
    send_cmd(make_cmd(FN_SPARE_B, 0, 0, 1'b0));
    set_domain(2047);
    send_cmd(make_cmd(FN_PUSH, 1023, 0, 1'b0));
    send_cmd(make_cmd(FN_PUSH, 0, 1023, 1'b1));
    send_cmd(make_cmd(FN_PUSH, 1023, 0, 1'b0));
    send_cmd(make_cmd(FN_FWD, 1023, 0, 1'b0));
    send_cmd(make_cmd(FN_FWD, 5, 0, 1'b0));
    send_cmd(make_cmd(FN_INV, 1, 0, 1'b0));
    send_cmd(make_cmd(FN_INV, 2, 0, 1'b0));
    // loaded entry leaves a hole below the largest value
    send_cmd(make_cmd(FN_LOAD, 5, 3, 1'b1));
    send_cmd(make_cmd(FN_INV, 2, 0, 1'b0));
    send_cmd(make_cmd(FN_FINISH, 0, 0, 1'b0));
    // next compact number already taken by a load
    send_cmd(make_cmd(FN_PUSH, 7, 0, 1'b0));
    send_cmd(make_cmd(FN_LOAD, 6, 1023, 1'b1));
    send_cmd(make_cmd(FN_LOAD, 8, 1023, 1'b1));
    send_cmd(make_cmd(FN_LOAD, 5, 9, 1'b1));
    send_cmd(make_cmd(FN_LOAD, 9, 0, 1'b0));
    send_cmd(make_cmd(FN_LOAD, 5, 0, 1'b0));
    send_cmd(make_cmd(FN_CLEAR, 0, 0, 1'b0));
    send_cmd(make_cmd(FN_FINISH, 0, 0, 1'b0));
    set_domain(16);
    send_cmd(make_cmd(FN_LOAD, 3, 16, 1'b1));
    send_cmd(make_cmd(FN_LOAD, 16, 0, 1'b1));
  endtask

  // push every domain index once so the count reaches the full table
  task automatic test_fill_map();
    int order [TABLE_DEPTH];
    set_domain(TABLE_DEPTH);
    send_cmd(make_cmd(FN_CLEAR, 0, 0, 1'b0));
    for (int i = 0; i < TABLE_DEPTH; i++) order[i] = i;
    shuffle_ints(order, TABLE_DEPTH);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_cmd(make_cmd(FN_PUSH, order[i], $urandom_range(0, 1023), 1'($urandom)));
    send_cmd(make_cmd(FN_INV, 1023, 0, 1'b0));
    send_cmd(make_cmd(FN_FWD, order[0], 0, 1'b0));
    send_cmd(make_cmd(FN_PUSH, order[5], 0, 1'b0));
    send_cmd(make_cmd(FN_FINISH, 0, 0, 1'b0));
  endtask

  // load partial permutations entry by entry, some of them broken
  task automatic test_load_permutation(input int rounds);
    int slots [TABLE_DEPTH];
    int vals  [TABLE_DEPTH];
    int dom;
    int n;
    int skip;
    for (int r = 0; r < rounds; r++) begin
      case ($urandom_range(0, 4))
        0: dom = 1;
        1: dom = TABLE_DEPTH;
        default: dom = $urandom_range(2, 64);
      endcase
      set_domain(dom);
      send_cmd(make_cmd(FN_CLEAR, 0, 0, 1'b0));
      n = $urandom_range(1, (dom < 24) ? dom : 24);
      for (int i = 0; i < dom; i++) slots[i] = i;
      for (int i = 0; i < n; i++) vals[i] = i;
      shuffle_ints(slots, dom);
      shuffle_ints(vals, n);
      // now and then leave one entry out
      skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int k = 0; k < n; k++) begin
        if (k != skip) send_cmd(make_cmd(FN_LOAD, slots[k], vals[k], 1'b1));
        case ($urandom_range(0, 9))
          0: send_cmd(make_cmd(FN_LOAD, slots[$urandom_range(0, dom - 1)],
                               $urandom_range(0, 1023), 1'b0));
          1: send_cmd(make_cmd(FN_FWD, slots[$urandom_range(0, dom - 1)], 0, 1'b0));
          2: send_cmd(make_cmd(FN_INV, $urandom_range(0, n), 0, 1'b0));
          3: send_cmd(make_cmd(FN_LOAD, slots[k], $urandom_range(0, dom - 1), 1'b1));
          4: send_cmd(make_cmd(FN_LOAD, slots[$urandom_range(0, dom - 1)],
                               vals[$urandom_range(0, k)], 1'b1));
          5: if (dom < TABLE_DEPTH)
               send_cmd(make_cmd(FN_LOAD, slots[$urandom_range(0, dom - 1)],
                                 $urandom_range(dom, 1023), 1'b1));
          default: ;
        endcase
      end
      send_cmd(make_cmd(FN_FINISH, 0, 0, 1'b0));
      for (int q = 0; q <= n / 2; q++) begin
        case ($urandom_range(0, 2))
          0: send_cmd(make_cmd(FN_PUSH, slots[$urandom_range(0, dom - 1)], 0, 1'b0));
          1: send_cmd(make_cmd(FN_FWD, slots[$urandom_range(0, dom - 1)], 0, 1'b0));
          default: send_cmd(make_cmd(FN_INV, $urandom_range(0, n), 0, 1'b0));
        endcase
      end
    end
  endtask

  // random mix of every operation under several domain sizes
  task automatic test_random_mix(input int phases, input int per_phase);
    int dom;
    int span;
    int idx;
    int val;
    int roll;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 5))
        0: dom = 0;
        1: dom = 1;
        2: dom = TABLE_DEPTH;
        3: dom = $urandom_range(TABLE_DEPTH + 1, 2047);
        default: dom = $urandom_range(2, 100);
      endcase
      set_domain(dom);
      span = (dom > TABLE_DEPTH) ? TABLE_DEPTH : dom;
      repeat (per_phase) begin
        idx = (span > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, span - 1)
                                                      : $urandom_range(0, 1023);
        val = (span > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, span - 1)
                                                      : $urandom_range(0, 1023);
        roll = $urandom_range(0, 99);
        if (roll < 2)
          send_cmd(make_cmd(FN_CLEAR, idx, val, 1'($urandom)));
        else if (roll < 32)
          send_cmd(make_cmd(FN_PUSH, idx, val, 1'($urandom)));
        else if (roll < 50)
          send_cmd(make_cmd(FN_FWD, idx, val, 1'($urandom)));
        else if (roll < 65)
          send_cmd(make_cmd(FN_INV, ($urandom_range(0, 3) != 0) ?
                            $urandom_range(0, (top_value > 1023) ? 1023 : int'(top_value)) :
                            idx, val, 1'($urandom)));
        else if (roll < 88)
          send_cmd(make_cmd(FN_LOAD, idx, val, $urandom_range(0, 4) != 0));
        else if (roll < 95)
          send_cmd(make_cmd(FN_FINISH, idx, val, 1'($urandom)));
        else
          send_cmd(make_cmd(($urandom_range(0, 1) != 0) ? FN_SPARE_A : FN_SPARE_B,
                            idx, val, 1'($urandom)));
      end
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with nothing expected: idx %0d part %0d count %0d status %0d",
                   result.mapped_index, result.is_participating, result.mapped_count,
                   result.status);
      end else begin
        want = awaited_results.pop_front();
        if (result.mapped_index !== want.mapped_index ||
            result.is_participating !== want.is_participating ||
            result.mapped_count !== want.mapped_count ||
            result.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected idx %0d part %0d count %0d status %0d",
                     want.mapped_index, want.is_participating, want.mapped_count,
                     want.status);
            $display("          got      idx %0d part %0d count %0d status %0d",
                     result.mapped_index, result.is_participating, result.mapped_count,
                     result.status);
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    int waited;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    mismatches   = 0;
    back_to_back = 1'b0;
    domain_cfg   = '0;
    wipe_maps();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_map();
    test_load_permutation(10);
    test_random_mix(6, 100);

    // drain outstanding results, then watch for strays
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
